/* hw/rtl/rcpsm_pkg.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper package
// Shared constants, configuration and control types for the mapper modules.
// ----------------------------------------------------------------------------
package rcpsm_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int NUM_AXES      = 4;
  localparam int AX_IDX_W      = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PULSE_W       = 16;
  localparam int REQ_W         = 24;

  // Axis codes.
  localparam logic [2:0] AX_ROLL     = 3'd1;
  localparam logic [2:0] AX_PITCH    = 3'd2;
  localparam logic [2:0] AX_THROTTLE = 3'd3;
  localparam logic [2:0] AX_YAW      = 3'd4;

  // Flight modes.
  localparam logic [1:0] MODE_ANGLE = 2'd0;
  localparam logic [1:0] MODE_RATE  = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_RNG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_RNG    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_THR_RNG = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TOL    = 3'd7;

  // Reset values.
  localparam logic [15:0] RST_VALID_MIN = 16'd800;
  localparam logic [15:0] RST_VALID_MAX = 16'd2200;
  localparam logic [15:0] RST_PULSE_MIN = 16'd1000;
  localparam logic [15:0] RST_PULSE_MAX = 16'd2000;
  localparam logic [15:0] RST_IDLE_TOL  = 16'd5;

  // Lanes within the range registers.
  localparam logic [1:0] LANE_ROLL_MIN  = 2'd0;
  localparam logic [1:0] LANE_ROLL_MAX  = 2'd1;
  localparam logic [1:0] LANE_PITCH_MIN = 2'd2;
  localparam logic [1:0] LANE_PITCH_MAX = 2'd3;
  localparam logic [1:0] LANE_YAW_MIN   = 2'd0;
  localparam logic [1:0] LANE_YAW_MAX   = 2'd1;
  localparam logic [1:0] LANE_THR_MIN   = 2'd2;
  localparam logic [1:0] LANE_THR_MAX   = 2'd3;

  typedef struct packed {
    logic [15:0] valid_pulse_min;
    logic [15:0] valid_pulse_max;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [63:0] angle_ranges;
    logic [63:0] rate_ranges;
    logic [63:0] yaw_throttle_ranges;
    logic [15:0] idle_tolerance;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic add;
    logic absv;
    logic div_step;
    logic fix;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic map_en;
  } sts_t;

  function automatic logic signed [15:0] lane(input logic [63:0] rng, input logic [1:0] k);
    logic signed [15:0] r;
    r = $signed(rng[16*k +: 16]);
    return r;
  endfunction

endpackage

/* hw/rtl/rcpsm_cfg.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper configuration registers
// Write-only register file with reset values, decoded from a register index.
// ----------------------------------------------------------------------------
module rcpsm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcpsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcpsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output rcpsm_pkg::cfg_t                     cfg_o
);

  rcpsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rcpsm_pkg::REG_VALID_MIN:   cfg_d.valid_pulse_min     = cfg_wdata_i[15:0];
        rcpsm_pkg::REG_VALID_MAX:   cfg_d.valid_pulse_max     = cfg_wdata_i[15:0];
        rcpsm_pkg::REG_PULSE_MIN:   cfg_d.pulse_min           = cfg_wdata_i[15:0];
        rcpsm_pkg::REG_PULSE_MAX:   cfg_d.pulse_max           = cfg_wdata_i[15:0];
        rcpsm_pkg::REG_ANGLE_RNG:   cfg_d.angle_ranges        = cfg_wdata_i;
        rcpsm_pkg::REG_RATE_RNG:    cfg_d.rate_ranges         = cfg_wdata_i;
        rcpsm_pkg::REG_YAW_THR_RNG: cfg_d.yaw_throttle_ranges = cfg_wdata_i;
        rcpsm_pkg::REG_IDLE_TOL:    cfg_d.idle_tolerance      = cfg_wdata_i[15:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_pulse_min     <= rcpsm_pkg::RST_VALID_MIN;
      cfg_q.valid_pulse_max     <= rcpsm_pkg::RST_VALID_MAX;
      cfg_q.pulse_min           <= rcpsm_pkg::RST_PULSE_MIN;
      cfg_q.pulse_max           <= rcpsm_pkg::RST_PULSE_MAX;
      cfg_q.angle_ranges        <= '0;
      cfg_q.rate_ranges         <= '0;
      cfg_q.yaw_throttle_ranges <= '0;
      cfg_q.idle_tolerance      <= rcpsm_pkg::RST_IDLE_TOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/rcpsm_ctrl.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper controller
// Sequences load, multiply, accumulate, divide and output steps of one beat.
// ----------------------------------------------------------------------------
module rcpsm_ctrl #(
  parameter int DIV_STEPS = 43
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  rcpsm_pkg::sts_t sts_i,
  output rcpsm_pkg::cmd_t cmd_o
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIX  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register can take a new beat when empty or when it drains now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = sts_i.map_en ? S_MUL2 : S_FIN;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_ABS;
      end
      S_ABS: begin
        cmd_o.absv = 1'b1;
        cnt_d      = CNT_W'(DIV_STEPS);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/rcpsm_dp.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper datapath
// Pulse sanitizing, shared multiplier, bit-serial divider, held requests and
// the output register.
// ----------------------------------------------------------------------------
module rcpsm_dp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcpsm_pkg::cfg_t                     cfg_i,
  input  rcpsm_pkg::cmd_t                     cmd_i,
  output rcpsm_pkg::sts_t                     sts_o,
  input  logic [2:0]                          func_i,
  input  logic [rcpsm_pkg::PULSE_W-1:0]       pulse_us_i,
  input  logic [1:0]                          flight_mode_i,
  output logic signed [rcpsm_pkg::REQ_W-1:0]  request_o,
  output logic                                warn_o,
  output logic                                throttle_idle_o
);

  localparam int REQ_W  = rcpsm_pkg::REQ_W;
  localparam int PROD_W = 34;
  localparam int ACC_W  = 35;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int TOL_W  = 16 + FRAC_BITS;
  localparam int CMP_W  = ((TOL_W > REQ_W) ? TOL_W : REQ_W) + 1;
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(24'h7FFFFF);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(24'h800000);
  localparam logic [rcpsm_pkg::AX_IDX_W-1:0] THR_IDX =
    rcpsm_pkg::AX_IDX_W'(rcpsm_pkg::AX_THROTTLE - 3'd1);

  // Item registers.
  logic [2:0]  func_q;
  logic [1:0]  mode_q;
  logic [15:0] p_q, p_d;
  logic        pwarn_q, pwarn_d;

  // Arithmetic registers.
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [NUM_W-1:0]         dvd_q, dvd_d;
  logic [15:0]              dvs_q, dvs_d;
  logic [15:0]              rem_q, rem_d;
  logic                     neg_q, neg_d;
  logic signed [REQ_W-1:0]  qsat_q, qsat_d;

  logic signed [REQ_W-1:0]  held_q [rcpsm_pkg::NUM_AXES];
  logic signed [REQ_W-1:0]  request_q;
  logic                     warn_q, idle_q;

  // Sanitized pulse.
  logic        in_bad;
  logic [16:0] mid_sum;
  always_comb begin
    in_bad  = (pulse_us_i < cfg_i.valid_pulse_min) || (pulse_us_i > cfg_i.valid_pulse_max);
    mid_sum = {1'b0, cfg_i.pulse_min} + {1'b0, cfg_i.pulse_max};
    pwarn_d = in_bad;
    if (in_bad) begin
      p_d = (func_i == rcpsm_pkg::AX_THROTTLE) ? cfg_i.pulse_min : mid_sum[16:1];
    end else if (pulse_us_i < cfg_i.pulse_min) begin
      p_d = cfg_i.pulse_min;
    end else if (pulse_us_i > cfg_i.pulse_max) begin
      p_d = cfg_i.pulse_max;
    end else begin
      p_d = pulse_us_i;
    end
  end

  // Axis decode and range selection.
  logic is_rp, is_thr, is_yaw, map_en, warn_item;
  logic signed [15:0] omin, omax;
  logic [rcpsm_pkg::AX_IDX_W-1:0] ax_idx;

  always_comb begin
    is_rp  = (func_q == rcpsm_pkg::AX_ROLL) || (func_q == rcpsm_pkg::AX_PITCH);
    is_thr = (func_q == rcpsm_pkg::AX_THROTTLE);
    is_yaw = (func_q == rcpsm_pkg::AX_YAW);
    map_en = is_thr || is_yaw ||
             (is_rp && ((mode_q == rcpsm_pkg::MODE_ANGLE) || (mode_q == rcpsm_pkg::MODE_RATE)));
    warn_item = pwarn_q || !(is_rp || is_thr || is_yaw) || (is_rp && !map_en);
    ax_idx = rcpsm_pkg::AX_IDX_W'(func_q - 3'd1);

    omin = rcpsm_pkg::lane(cfg_i.yaw_throttle_ranges, rcpsm_pkg::LANE_YAW_MIN);
    omax = rcpsm_pkg::lane(cfg_i.yaw_throttle_ranges, rcpsm_pkg::LANE_YAW_MAX);
    if (is_thr) begin
      omin = rcpsm_pkg::lane(cfg_i.yaw_throttle_ranges, rcpsm_pkg::LANE_THR_MIN);
      omax = rcpsm_pkg::lane(cfg_i.yaw_throttle_ranges, rcpsm_pkg::LANE_THR_MAX);
    end else if (is_rp) begin
      if (func_q == rcpsm_pkg::AX_ROLL) begin
        omin = rcpsm_pkg::lane((mode_q == rcpsm_pkg::MODE_ANGLE) ? cfg_i.angle_ranges
                               : cfg_i.rate_ranges, rcpsm_pkg::LANE_ROLL_MIN);
        omax = rcpsm_pkg::lane((mode_q == rcpsm_pkg::MODE_ANGLE) ? cfg_i.angle_ranges
                               : cfg_i.rate_ranges, rcpsm_pkg::LANE_ROLL_MAX);
      end else begin
        omin = rcpsm_pkg::lane((mode_q == rcpsm_pkg::MODE_ANGLE) ? cfg_i.angle_ranges
                               : cfg_i.rate_ranges, rcpsm_pkg::LANE_PITCH_MIN);
        omax = rcpsm_pkg::lane((mode_q == rcpsm_pkg::MODE_ANGLE) ? cfg_i.angle_ranges
                               : cfg_i.rate_ranges, rcpsm_pkg::LANE_PITCH_MAX);
      end
    end
  end

  assign sts_o.map_en = map_en;

  // Window span, pulse offset and range span, all 17-bit signed.
  logic signed [16:0] span_d, off_p, span_r;
  logic               dz;
  logic signed [16:0] mul_a, mul_b;
  assign span_d = $signed({1'b0, cfg_i.pulse_max}) - $signed({1'b0, cfg_i.pulse_min});
  assign off_p  = $signed({1'b0, p_q}) - $signed({1'b0, cfg_i.pulse_min});
  assign span_r = $signed({omax[15], omax}) - $signed({omin[15], omin});
  assign dz     = (span_d == 17'sd0);
  assign mul_a  = cmd_i.mul1 ? $signed({omin[15], omin}) : off_p;
  assign mul_b  = cmd_i.mul1 ? span_d : span_r;

  // Divider step and saturation logic.
  logic [16:0]        trial;
  logic               qbit;
  logic [ACC_W-1:0]   acc_mag;
  logic [16:0]        span_mag;
  logic [REQ_W-1:0]   mag_lo;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    qsat_d = qsat_q;

    trial    = {rem_q, dvd_q[NUM_W-1]};
    qbit     = (trial >= {1'b0, dvs_q});
    acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    span_mag = span_d[16] ? 17'(-span_d) : 17'(span_d);
    mag_lo   = dvd_q[REQ_W-1:0];

    if (cmd_i.mul1 || cmd_i.mul2) begin
      prod_d = mul_a * mul_b;
    end
    if (cmd_i.mul2) begin
      acc_d = $signed({prod_q[PROD_W-1], prod_q});
    end
    if (cmd_i.add) begin
      // An empty working window gives the range low end: divide it by one.
      acc_d = dz ? ACC_W'(omin) : acc_q + $signed({prod_q[PROD_W-1], prod_q});
    end
    if (cmd_i.absv) begin
      dvd_d = NUM_W'(acc_mag) << FRAC_BITS;
      dvs_d = dz ? 16'd1 : span_mag[15:0];
      rem_d = '0;
      neg_d = acc_q[ACC_W-1] ^ span_d[16];
    end
    if (cmd_i.div_step) begin
      rem_d = qbit ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      dvd_d = {dvd_q[NUM_W-2:0], qbit};
    end
    if (cmd_i.fix) begin
      if (neg_q) begin
        qsat_d = (dvd_q > NEG_LIM) ? $signed(24'h800000) : $signed(-mag_lo);
      end else begin
        qsat_d = (dvd_q > POS_LIM) ? $signed(24'h7FFFFF) : $signed(mag_lo);
      end
    end
  end

  // Output selection and the throttle idle compare against the updated state.
  logic signed [REQ_W-1:0] req_sel, thr_new;
  logic [CMP_W-1:0]        tol_ext, thr_ext;
  always_comb begin
    if (map_en) begin
      req_sel = qsat_q;
    end else if (is_rp) begin
      req_sel = held_q[ax_idx];
    end else begin
      req_sel = '0;
    end
    thr_new = (map_en && is_thr) ? qsat_q : held_q[THR_IDX];
    tol_ext = {{(CMP_W - 16){cfg_i.idle_tolerance[15]}}, cfg_i.idle_tolerance} << FRAC_BITS;
    thr_ext = {{(CMP_W - REQ_W){thr_new[REQ_W-1]}}, thr_new};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      mode_q  <= flight_mode_i;
      p_q     <= p_d;
      pwarn_q <= pwarn_d;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    qsat_q <= qsat_d;
    if (cmd_i.emit) begin
      request_q <= req_sel;
      warn_q    <= warn_item;
      idle_q    <= ($signed(thr_ext) <= $signed(tol_ext));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcpsm_pkg::NUM_AXES; i++) begin
        held_q[i] <= '0;
      end
    end else if (cmd_i.emit && map_en) begin
      held_q[ax_idx] <= qsat_q;
    end
  end

  assign request_o       = request_q;
  assign warn_o          = warn_q;
  assign throttle_idle_o = idle_q;

endmodule

/* hw/rtl/rc_pulse_setpoint_mapper_core.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper core
// Maps one RC pulse width per beat onto a signed Q setpoint for its axis.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_stall_o   func_i, pulse_us_i, flight_mode_i
//   out      source     out_valid_o/out_stall_i request_o, warn_o, throttle_idle_o
//   cfg      sink       cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A mapped beat passes through acceptance, two passes of one shared
// multiplier, accumulate, magnitude, 35 + FRAC_BITS steps of a one-bit
// restoring divider, saturation and output load. Beats that need no mapping
// (undefined mode, invalid axis) go from one multiplier pass to output load.
// Reset clears the configuration to its defaults and the held requests to zero.
// The input stalls while a beat is in work; a stalled output holds its beat,
// and a new input beat is accepted while that result waits.
// ----------------------------------------------------------------------------
module rc_pulse_setpoint_mapper_core #(
  parameter int FRAC_BITS = rcpsm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          func_i,
  input  logic [rcpsm_pkg::PULSE_W-1:0]       pulse_us_i,
  input  logic [1:0]                          flight_mode_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rcpsm_pkg::REQ_W-1:0]  request_o,
  output logic                                warn_o,
  output logic                                throttle_idle_o,
  input  logic                                cfg_we_i,
  input  logic [rcpsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcpsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int DIV_STEPS = 35 + FRAC_BITS;

  rcpsm_pkg::cfg_t cfg;
  rcpsm_pkg::cmd_t cmd;
  rcpsm_pkg::sts_t sts;

  rcpsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rcpsm_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rcpsm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .pulse_us_i      (pulse_us_i),
    .flight_mode_i   (flight_mode_i),
    .request_o       (request_o),
    .warn_o          (warn_o),
    .throttle_idle_o (throttle_idle_o)
  );

endmodule

/* bench/tb_rc_pulse_setpoint_mapper_core.sv */
// ----------------------------------------------------------------------------
// RC pulse setpoint mapper testbench
// Drives pulse beats through the mapper under several register settings and
// checks every setpoint beat against a predictor of the mapping, the held
// values per axis and the throttle idle flag. Both channels pause at random.
// ----------------------------------------------------------------------------
module tb_rc_pulse_setpoint_mapper_core;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ITEMS_PER_PHASE = 75;
  localparam int     REQ_W = rcpsm_pkg::REQ_W;
  localparam longint Q_SCALE = longint'(1) << rcpsm_pkg::FRAC_BITS_DEF;
  localparam longint REQ_HI = (longint'(1) << (REQ_W - 1)) - 1;
  localparam longint REQ_LO = -(longint'(1) << (REQ_W - 1));

  // Slots of the held setpoints, one per axis.
  localparam int SLOT_ROLL     = 0;
  localparam int SLOT_PITCH    = 1;
  localparam int SLOT_THROTTLE = 2;
  localparam int SLOT_YAW      = 3;

  typedef struct {
    logic [2:0]                        func;
    logic [rcpsm_pkg::PULSE_W-1:0]     pulse;
    logic signed [REQ_W-1:0]           request;
    logic                              warn;
    logic                              idle;
  } setpoint_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [2:0]                          func_i = '0;
  logic [rcpsm_pkg::PULSE_W-1:0]       pulse_us_i = '0;
  logic [1:0]                          flight_mode_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [REQ_W-1:0]             request_o;
  logic                                warn_o;
  logic                                throttle_idle_o;
  logic                                cfg_we_i = 1'b0;
  logic [rcpsm_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [rcpsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i = '0;

  // Predictor copy of the registers and of the held setpoints.
  logic [15:0]             cfg_valid_min = rcpsm_pkg::RST_VALID_MIN;
  logic [15:0]             cfg_valid_max = rcpsm_pkg::RST_VALID_MAX;
  logic [15:0]             cfg_pulse_min = rcpsm_pkg::RST_PULSE_MIN;
  logic [15:0]             cfg_pulse_max = rcpsm_pkg::RST_PULSE_MAX;
  logic [63:0]             cfg_angle = '0;
  logic [63:0]             cfg_rate = '0;
  logic [63:0]             cfg_yaw_thr = '0;
  logic [15:0]             cfg_idle_tol = rcpsm_pkg::RST_IDLE_TOL;
  logic signed [REQ_W-1:0] held_setpoint [rcpsm_pkg::NUM_AXES] = '{default: '0};

  setpoint_t pending_setpoints [$];
  int        setpoint_errors = 0;
  int        quiet_cycles = 0;
  int        gap_max = 3;
  int        stall_level = 8;
  int        burst_left = 0;
  int        stall_run = 0;

  rc_pulse_setpoint_mapper_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .pulse_us_i     (pulse_us_i),
    .flight_mode_i  (flight_mode_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .request_o      (request_o),
    .warn_o         (warn_o),
    .throttle_idle_o(throttle_idle_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] range_end(input logic [63:0] rng,
                                                    input logic [1:0] k);
    return rng[16*k +: 16];
  endfunction

  function automatic logic signed [63:0] pack_ends(input logic signed [15:0] e0, e1, e2, e3);
    return {e3, e2, e1, e0};
  endfunction

  // Exact linear map of the working window onto [lo_end, hi_end] in Q form.
  function automatic logic signed [REQ_W-1:0] map_pulse(input logic [15:0] p,
                                                         input logic signed [15:0] lo_end,
                                                         input logic signed [15:0] hi_end);
    longint p_l, lo_l, hi_l, pmin_l, pmax_l, span, q;
    p_l = longint'(p);
    lo_l = longint'(lo_end);
    hi_l = longint'(hi_end);
    pmin_l = longint'(cfg_pulse_min);
    pmax_l = longint'(cfg_pulse_max);
    span = pmax_l - pmin_l;
    if (span == 0) begin
      q = lo_l * Q_SCALE;
    end else begin
      q = (lo_l * span * Q_SCALE + (p_l - pmin_l) * (hi_l - lo_l) * Q_SCALE) / span;
    end
    if (q > REQ_HI) q = REQ_HI;
    if (q < REQ_LO) q = REQ_LO;
    return q[REQ_W-1:0];
  endfunction

  task automatic predict_setpoint(input logic [2:0] func, input logic [15:0] pulse,
                                  input logic [1:0] mode);
    setpoint_t               sp;
    logic [15:0]             p;
    logic signed [15:0]      tol;
    logic [63:0]             rng;
    int                      slot;
    longint                  thr, idle_limit;
    sp.func = func;
    sp.pulse = pulse;
    sp.warn = 1'b0;
    sp.request = '0;
    if (pulse < cfg_valid_min || pulse > cfg_valid_max) begin
      sp.warn = 1'b1;
      p = (func == rcpsm_pkg::AX_THROTTLE) ? cfg_pulse_min
          : 16'((32'(cfg_pulse_min) + 32'(cfg_pulse_max)) >> 1);
    end else if (pulse < cfg_pulse_min) begin
      p = cfg_pulse_min;
    end else if (pulse > cfg_pulse_max) begin
      p = cfg_pulse_max;
    end else begin
      p = pulse;
    end
    case (func)
      rcpsm_pkg::AX_ROLL, rcpsm_pkg::AX_PITCH: begin
        slot = (func == rcpsm_pkg::AX_ROLL) ? SLOT_ROLL : SLOT_PITCH;
        rng = (mode == rcpsm_pkg::MODE_ANGLE) ? cfg_angle : cfg_rate;
        if (mode == rcpsm_pkg::MODE_ANGLE || mode == rcpsm_pkg::MODE_RATE) begin
          if (func == rcpsm_pkg::AX_ROLL) begin
            held_setpoint[slot] = map_pulse(p, range_end(rng, rcpsm_pkg::LANE_ROLL_MIN),
                                            range_end(rng, rcpsm_pkg::LANE_ROLL_MAX));
          end else begin
            held_setpoint[slot] = map_pulse(p, range_end(rng, rcpsm_pkg::LANE_PITCH_MIN),
                                            range_end(rng, rcpsm_pkg::LANE_PITCH_MAX));
          end
        end else begin
          // Undefined mode keeps the last setpoint of the axis.
          sp.warn = 1'b1;
        end
        sp.request = held_setpoint[slot];
      end
      rcpsm_pkg::AX_THROTTLE: begin
        held_setpoint[SLOT_THROTTLE] =
          map_pulse(p, range_end(cfg_yaw_thr, rcpsm_pkg::LANE_THR_MIN),
                    range_end(cfg_yaw_thr, rcpsm_pkg::LANE_THR_MAX));
        sp.request = held_setpoint[SLOT_THROTTLE];
      end
      rcpsm_pkg::AX_YAW: begin
        held_setpoint[SLOT_YAW] =
          map_pulse(p, range_end(cfg_yaw_thr, rcpsm_pkg::LANE_YAW_MIN),
                    range_end(cfg_yaw_thr, rcpsm_pkg::LANE_YAW_MAX));
        sp.request = held_setpoint[SLOT_YAW];
      end
      default: begin
        sp.warn = 1'b1;
      end
    endcase
    tol = cfg_idle_tol;
    idle_limit = longint'(tol) * Q_SCALE;
    thr = longint'(held_setpoint[SLOT_THROTTLE]);
    sp.idle = (thr <= idle_limit);
    pending_setpoints.push_back(sp);
  endtask

  task automatic write_reg(input logic [rcpsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      rcpsm_pkg::REG_VALID_MIN:   cfg_valid_min = data[15:0];
      rcpsm_pkg::REG_VALID_MAX:   cfg_valid_max = data[15:0];
      rcpsm_pkg::REG_PULSE_MIN:   cfg_pulse_min = data[15:0];
      rcpsm_pkg::REG_PULSE_MAX:   cfg_pulse_max = data[15:0];
      rcpsm_pkg::REG_ANGLE_RNG:   cfg_angle = data;
      rcpsm_pkg::REG_RATE_RNG:    cfg_rate = data;
      rcpsm_pkg::REG_YAW_THR_RNG: cfg_yaw_thr = data;
      rcpsm_pkg::REG_IDLE_TOL:    cfg_idle_tol = data[15:0];
      default: ;
    endcase
  endtask

  // Writes every register; the narrow ones carry random upper bits.
  task automatic set_config(input logic [15:0] vmin, vmax, pmin, pmax,
                            input logic [63:0] angle, rate, yaw_thr,
                            input logic [15:0] tol);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    write_reg(rcpsm_pkg::REG_VALID_MIN, {junk, vmin});
    write_reg(rcpsm_pkg::REG_VALID_MAX, {junk, vmax});
    write_reg(rcpsm_pkg::REG_PULSE_MIN, {junk, pmin});
    write_reg(rcpsm_pkg::REG_PULSE_MAX, {junk, pmax});
    write_reg(rcpsm_pkg::REG_ANGLE_RNG, angle);
    write_reg(rcpsm_pkg::REG_RATE_RNG, rate);
    write_reg(rcpsm_pkg::REG_YAW_THR_RNG, yaw_thr);
    write_reg(rcpsm_pkg::REG_IDLE_TOL, {junk, tol});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pulse(input logic [2:0] func, input logic [15:0] pulse,
                            input logic [1:0] mode);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    func_i <= func;
    pulse_us_i <= pulse;
    flight_mode_i <= mode;
    do @(posedge clk_i); while (in_stall_o);
    predict_setpoint(func, pulse, mode);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_setpoints.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // All ranges are zero after reset, so every setpoint is zero.
  task automatic test_reset_defaults();
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd1500, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd700, rcpsm_pkg::MODE_RATE);
    send_pulse(3'd7, 16'd2200, rcpsm_pkg::MODE_ANGLE);
    wait_idle();
  endtask

  task automatic test_axis_mapping();
    set_config(16'd800, 16'd2200, 16'd1000, 16'd2000,
               pack_ends(-16'sd45, 16'sd45, -16'sd30, 16'sd30),
               pack_ends(-16'sd200, 16'sd250, -16'sd150, 16'sd100),
               pack_ends(-16'sd180, 16'sd180, 16'sd0, 16'sd100), 16'd5);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd1000, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd2000, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_PITCH, 16'd1333, rcpsm_pkg::MODE_RATE);
    send_pulse(rcpsm_pkg::AX_PITCH, 16'd2200, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd800, rcpsm_pkg::MODE_RATE);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd799, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd1049, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd2201, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_YAW, 16'd1777, 2'd3);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd1900, 2'd2);
    send_pulse(rcpsm_pkg::AX_PITCH, 16'd1100, 2'd3);
    send_pulse(3'd0, 16'd0, rcpsm_pkg::MODE_ANGLE);
    send_pulse(3'd5, 16'd65535, rcpsm_pkg::MODE_RATE);
    send_pulse(3'd6, 16'd1500, rcpsm_pkg::MODE_ANGLE);
    send_pulse(3'd7, 16'd1500, rcpsm_pkg::MODE_RATE);
    wait_idle();
  endtask

  task automatic test_window_corners();
    logic [63:0] spread;
    spread = pack_ends(-16'sd90, 16'sd90, 16'sd10, -16'sd10);
    // A reversed validity window rejects every pulse.
    set_config(16'd2000, 16'd1000, 16'd1000, 16'd2000, spread, spread, spread, 16'd0);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd1500, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd1500, rcpsm_pkg::MODE_ANGLE);
    wait_idle();
    // A reversed working window clamps to one of its two ends.
    set_config(16'd600, 16'd2400, 16'd2000, 16'd1000, spread, spread, spread, 16'd0);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd900, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_PITCH, 16'd2300, rcpsm_pkg::MODE_RATE);
    send_pulse(rcpsm_pkg::AX_YAW, 16'd1500, rcpsm_pkg::MODE_ANGLE);
    wait_idle();
    // An empty working window gives the low end of the range.
    set_config(16'd800, 16'd2200, 16'd1500, 16'd1500, spread, spread, spread, 16'd0);
    send_pulse(rcpsm_pkg::AX_YAW, 16'd1700, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd1500, rcpsm_pkg::MODE_RATE);
    wait_idle();
    set_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
               pack_ends(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF),
               pack_ends(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000),
               pack_ends(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF), 16'h8000);
    send_pulse(rcpsm_pkg::AX_ROLL, 16'd0, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_PITCH, 16'hFFFF, rcpsm_pkg::MODE_RATE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'd0, rcpsm_pkg::MODE_ANGLE);
    send_pulse(rcpsm_pkg::AX_THROTTLE, 16'hFFFF, 2'd2);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [15:0] vmin, vmax, pmin, pmax, tol, pulse;
    logic [63:0] angle, rate, yaw_thr;
    logic [2:0]  func;
    logic [1:0]  mode;
    int          pick, lo_i, hi_i;
    for (int phase = 0; phase < 8; phase++) begin
      vmin = 16'($urandom_range(500, 1000));
      vmax = vmin + 16'($urandom_range(900, 1700));
      pmin = vmin + 16'($urandom_range(0, 250));
      pmax = vmax - 16'($urandom_range(0, 250));
      angle = {$urandom, $urandom};
      rate = {$urandom, $urandom};
      yaw_thr = {16'($urandom_range(80, 120)), 16'($urandom_range(0, 20)), 32'($urandom)};
      tol = 16'($urandom_range(0, 60));
      case (phase)
        2: begin
          vmin = 16'd0;
          vmax = 16'hFFFF;
          pmin = 16'd0;
          pmax = 16'hFFFF;
          angle = pack_ends(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
          yaw_thr = pack_ends(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
          tol = 16'h7FFF;
        end
        3: begin
          vmin = 16'($urandom);
          vmax = 16'($urandom);
          pmin = 16'($urandom);
          pmax = 16'($urandom);
          yaw_thr = {$urandom, $urandom};
          tol = 16'($urandom);
        end
        4: begin
          vmin = 16'd600;
          vmax = 16'd2400;
          pmin = 16'($urandom_range(1600, 2200));
          pmax = 16'($urandom_range(800, 1400));
        end
        5: begin
          pmin = 16'($urandom_range(900, 2100));
          pmax = pmin;
        end
        default: ;
      endcase
      gap_max = (phase == 1) ? 0 : (phase == 6) ? 2 : (phase == 7) ? 40 : 6;
      stall_level = (phase == 1) ? 0 : (phase == 6) ? 40 : (phase == 7) ? 5 : 10;
      set_config(vmin, vmax, pmin, pmax, angle, rate, yaw_thr, tol);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        func = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(1, 4))
                                             : 3'($urandom_range(0, 7));
        mode = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                             : 2'($urandom_range(2, 3));
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          lo_i = int'(cfg_valid_min) - 40;
          hi_i = int'(cfg_valid_max) + 40;
          if (lo_i < 0) lo_i = 0;
          if (hi_i > 65535) hi_i = 65535;
          pulse = 16'($urandom_range(hi_i, lo_i));
        end else if (pick < 80) begin
          case ($urandom_range(0, 5))
            0: pulse = cfg_valid_min;
            1: pulse = cfg_valid_max;
            2: pulse = cfg_pulse_min;
            3: pulse = cfg_pulse_max;
            4: pulse = cfg_valid_min - 16'd1;
            default: pulse = cfg_valid_max + 16'd1;
          endcase
        end else begin
          pulse = 16'($urandom_range(0, 65535));
        end
        send_pulse(func, pulse, mode);
      end
      wait_idle();
    end
  endtask

  always @(posedge clk_i) begin : check_setpoints
    setpoint_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_setpoints.size() == 0) begin
          setpoint_errors++;
          if (setpoint_errors <= 10) begin
            $display("unexpected setpoint beat: request %0d warn %0b idle %0b",
                     request_o, warn_o, throttle_idle_o);
          end
        end else begin
          want = pending_setpoints.pop_front();
          if (request_o !== want.request || warn_o !== want.warn ||
              throttle_idle_o !== want.idle) begin
            setpoint_errors++;
            if (setpoint_errors <= 10) begin
              $display("setpoint mismatch, axis %0d pulse %0d: expected request %0d warn %0b",
                       want.func, want.pulse, want.request, want.warn);
              $display("  idle %0b, got request %0d warn %0b idle %0b",
                       want.idle, request_o, warn_o, throttle_idle_o);
            end
          end
        end
      end
      // Receiver alternates free runs with stall runs of random length.
      if (stall_run != 0) begin
        stall_run--;
      end else if (out_stall_i || stall_level == 0) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 15);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, stall_level);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_axis_mapping();
    test_window_corners();
    test_random_traffic();
    repeat (64) @(posedge clk_i);
    if (setpoint_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rcpsm_pkg.sv
hw/rtl/rcpsm_cfg.sv
hw/rtl/rcpsm_ctrl.sv
hw/rtl/rcpsm_dp.sv
hw/rtl/rc_pulse_setpoint_mapper_core.sv
bench/tb_rc_pulse_setpoint_mapper_core.sv
